FILE: sv/tcs_pkg.sv
// Shared types, constants and helpers for the timed counting semaphore.
package tcs_pkg;

  localparam int MAX_WAITERS  = 16;
  localparam int TIMEOUT_BITS = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int IDX_W        = $clog2(MAX_WAITERS);
  localparam int SIZE_W       = $clog2(MAX_WAITERS + 1);
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W      = 18;
  localparam int COUNT_TOP    = 65535;
  localparam logic [31:0] TMAX = 32'((64'd1 << TIMEOUT_BITS) - 64'd1);

  typedef enum logic [1:0] {
    CMD_WAIT   = 2'd0,
    CMD_SIGNAL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_GRANTED  = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_SIG_REL  = 3'd3,
    KIND_TMO_REL  = 3'd4,
    KIND_SIG_NONE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TICK
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_SIGNAL,
    OP_TICK_DEC,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_INSERT,
    OP_POP_TICK
  } op_t;

  typedef struct packed {
    logic                      out_free;
    logic                      timed_block;
    logic                      walk_more;
    logic                      due;
    logic signed [COUNT_W-1:0] count;
    logic [SIZE_W-1:0]         fifo_size;
    logic [SIZE_W-1:0]         list_size;
  } dp_status_t;

  // Clamp a requested timeout to the largest delta the list can hold.
  function automatic logic [TIMEOUT_BITS-1:0] sat_delta(input logic [15:0] t);
    logic [31:0] t32;
    t32 = 32'(t);
    if (t32 > TMAX) return TIMEOUT_BITS'(TMAX);
    return TIMEOUT_BITS'(t32);
  endfunction

endpackage

FILE: sv/tcs_ctrl.sv
// Controller state machine: sequences waits, signals, insert walks and tick releases.
module tcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  input  tcs_pkg::dp_status_t st,
  output logic                in_stall,
  output logic                cfg_ready,
  output tcs_pkg::op_t        op
);

  tcs_pkg::state_t state_r, state_nxt;
  tcs_pkg::cmd_t   cmd;

  assign cmd = tcs_pkg::cmd_t'(in_cmd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcs_pkg::ST_IDLE: begin
        if (in_valid && st.out_free) begin
          if (cmd == tcs_pkg::CMD_WAIT && st.timed_block) state_nxt = tcs_pkg::ST_WALK;
          else if (cmd == tcs_pkg::CMD_TICK) state_nxt = tcs_pkg::ST_TICK;
        end
      end
      tcs_pkg::ST_WALK: begin
        if (!st.walk_more) state_nxt = tcs_pkg::ST_IDLE;
      end
      tcs_pkg::ST_TICK: begin
        if (!st.due) state_nxt = tcs_pkg::ST_IDLE;
      end
      default: state_nxt = tcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op        = tcs_pkg::OP_NOP;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      tcs_pkg::ST_IDLE: begin
        in_stall  = !st.out_free;
        cfg_ready = 1'b1;
        if (in_valid && st.out_free) begin
          unique case (cmd)
            tcs_pkg::CMD_WAIT:   op = st.timed_block ? tcs_pkg::OP_WALK_START : tcs_pkg::OP_WAIT;
            tcs_pkg::CMD_SIGNAL: op = tcs_pkg::OP_SIGNAL;
            tcs_pkg::CMD_TICK:   op = tcs_pkg::OP_TICK_DEC;
            tcs_pkg::CMD_NONE:   op = tcs_pkg::OP_NOP;
          endcase
        end
      end
      tcs_pkg::ST_WALK: begin
        op = st.walk_more ? tcs_pkg::OP_WALK_STEP : tcs_pkg::OP_INSERT;
      end
      tcs_pkg::ST_TICK: begin
        if (st.due && st.out_free) op = tcs_pkg::OP_POP_TICK;
      end
      default: op = tcs_pkg::OP_NOP;
    endcase
  end

endmodule

FILE: sv/tcs_datapath.sv
// Datapath: count, untimed FIFO, delta-encoded timed list and result register.
module tcs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcs_pkg::op_t        op,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          in_thread_id,
  input  logic [15:0]         in_timeout,
  input  logic                out_stall,
  output tcs_pkg::dp_status_t st,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_released_thread,
  output logic signed [16:0]  out_count_now,
  output logic                out_last
);

  localparam int MW = tcs_pkg::MAX_WAITERS;
  localparam int TB = tcs_pkg::TIMEOUT_BITS;
  localparam int IW = tcs_pkg::IDX_W;
  localparam int SW = tcs_pkg::SIZE_W;
  localparam int RW = tcs_pkg::RES_W;
  localparam int CW = tcs_pkg::COUNT_W;
  localparam logic signed [CW-1:0] TOP_S = CW'(tcs_pkg::COUNT_TOP);

  logic [15:0]          init_r, init_nxt;
  logic signed [CW-1:0] count_r, count_nxt, c1;
  logic [7:0]           fifo_r [MW];
  logic [7:0]           fifo_nxt [MW];
  logic [IW-1:0]        fhead_r, fhead_nxt;
  logic [SW-1:0]        fsize_r, fsize_nxt;
  logic [7:0]           thr_r [MW];
  logic [7:0]           thr_nxt [MW];
  logic [TB-1:0]        dl_r [MW];
  logic [TB-1:0]        dl_nxt [MW];
  logic [SW-1:0]        lsize_r, lsize_nxt;
  logic [SW-1:0]        pos_r, pos_nxt;
  logic [TB-1:0]        d_r, d_nxt;
  logic [7:0]           tid_r, tid_nxt;
  logic [RW-1:0]        nres_r, nres_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tcs_pkg::kind_t       kind_r;
  logic [7:0]           thread_r;
  logic signed [16:0]   cnow_r;
  logic                 last_r;

  logic                 emit, e_last;
  tcs_pkg::kind_t       e_kind;
  logic [7:0]           e_thr;
  logic                 grant, fifo_full, list_full, due_after, out_free;
  logic [IW-1:0]        pos_idx, slot;
  logic [SW:0]          ssum;

  assign out_free  = !out_valid_r || !out_stall;
  assign grant     = count_r > 0;
  assign fifo_full = fsize_r == SW'(MW);
  assign list_full = lsize_r == SW'(MW);
  assign pos_idx   = pos_r[IW-1:0];
  assign c1        = (count_r < TOP_S) ? count_r + CW'(1) : count_r;
  assign due_after = (lsize_r > SW'(1)) && (dl_r[1] == '0) &&
                     ((nres_r + RW'(1)) < RW'(tcs_pkg::MAX_RESULTS));

  always_comb begin
    ssum = (SW+1)'(fhead_r) + (SW+1)'(fsize_r);
    if (ssum >= (SW+1)'(MW)) ssum = ssum - (SW+1)'(MW);
    slot = ssum[IW-1:0];
  end

  always_comb begin
    st.out_free    = out_free;
    st.timed_block = !grant && (in_timeout != '0) && !list_full;
    st.walk_more   = (pos_r < lsize_r) && (d_r > dl_r[pos_idx]);
    st.due         = (lsize_r != '0) && (dl_r[0] == '0) &&
                     (nres_r < RW'(tcs_pkg::MAX_RESULTS));
    st.count       = count_r;
    st.fifo_size   = fsize_r;
    st.list_size   = lsize_r;
  end

  always_comb begin
    init_nxt  = init_r;
    count_nxt = count_r;
    fifo_nxt  = fifo_r;
    fhead_nxt = fhead_r;
    fsize_nxt = fsize_r;
    thr_nxt   = thr_r;
    dl_nxt    = dl_r;
    lsize_nxt = lsize_r;
    pos_nxt   = pos_r;
    d_nxt     = d_r;
    tid_nxt   = tid_r;
    nres_nxt  = nres_r;
    emit      = 1'b0;
    e_kind    = tcs_pkg::KIND_GRANTED;
    e_thr     = tid_r;
    e_last    = 1'b1;
    unique case (op)
      tcs_pkg::OP_NOP: ;
      tcs_pkg::OP_WAIT: begin
        emit  = 1'b1;
        e_thr = in_thread_id;
        if (grant) begin
          count_nxt = count_r - CW'(1);
        end else if (in_timeout == '0 && !fifo_full) begin
          fifo_nxt[slot] = in_thread_id;
          fsize_nxt      = fsize_r + SW'(1);
          count_nxt      = count_r - CW'(1);
          e_kind         = tcs_pkg::KIND_BLOCKED;
        end else begin
          e_kind = tcs_pkg::KIND_FULL;
        end
      end
      tcs_pkg::OP_WALK_START: begin
        tid_nxt = in_thread_id;
        d_nxt   = tcs_pkg::sat_delta(in_timeout);
        pos_nxt = '0;
      end
      tcs_pkg::OP_WALK_STEP: begin
        d_nxt   = d_r - dl_r[pos_idx];
        pos_nxt = pos_r + SW'(1);
      end
      tcs_pkg::OP_INSERT: begin
        for (int k = 0; k < MW; k++) begin
          if (SW'(k) == pos_r) begin
            thr_nxt[k] = tid_r;
            dl_nxt[k]  = d_r;
          end else if (SW'(k) > pos_r) begin
            thr_nxt[k] = thr_r[(k > 0) ? k - 1 : 0];
            if ((SW'(k) == pos_r + SW'(1)) && (pos_r < lsize_r))
              dl_nxt[k] = dl_r[(k > 0) ? k - 1 : 0] - d_r;
            else dl_nxt[k] = dl_r[(k > 0) ? k - 1 : 0];
          end
        end
        lsize_nxt = lsize_r + SW'(1);
        count_nxt = count_r - CW'(1);
        emit      = 1'b1;
        e_kind    = tcs_pkg::KIND_BLOCKED;
      end
      tcs_pkg::OP_SIGNAL: begin
        count_nxt = c1;
        emit      = 1'b1;
        if (c1 <= 0 && fsize_r != '0) begin
          e_kind    = tcs_pkg::KIND_SIG_REL;
          e_thr     = fifo_r[fhead_r];
          fhead_nxt = (fhead_r == IW'(MW - 1)) ? '0 : fhead_r + IW'(1);
          fsize_nxt = fsize_r - SW'(1);
        end else if (c1 <= 0 && lsize_r != '0) begin
          e_kind = tcs_pkg::KIND_SIG_REL;
          e_thr  = thr_r[0];
          for (int k = 0; k < MW - 1; k++) begin
            thr_nxt[k] = thr_r[k+1];
            dl_nxt[k]  = dl_r[k+1];
          end
          dl_nxt[0] = dl_r[1] + dl_r[0];
          lsize_nxt = lsize_r - SW'(1);
        end else begin
          e_kind = tcs_pkg::KIND_SIG_NONE;
          e_thr  = '0;
        end
      end
      tcs_pkg::OP_TICK_DEC: begin
        nres_nxt = '0;
        if (lsize_r != '0 && dl_r[0] != '0) dl_nxt[0] = dl_r[0] - TB'(1);
      end
      tcs_pkg::OP_POP_TICK: begin
        for (int k = 0; k < MW - 1; k++) begin
          thr_nxt[k] = thr_r[k+1];
          dl_nxt[k]  = dl_r[k+1];
        end
        dl_nxt[0] = dl_r[1] + dl_r[0];
        lsize_nxt = lsize_r - SW'(1);
        count_nxt = count_r + CW'(1);
        nres_nxt  = nres_r + RW'(1);
        emit      = 1'b1;
        e_kind    = tcs_pkg::KIND_TMO_REL;
        e_thr     = thr_r[0];
        e_last    = !due_after;
      end
    endcase
    if (cfg_we) begin
      init_nxt = cfg_data;
      if (fsize_r == '0 && lsize_r == '0) count_nxt = CW'(cfg_data);
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= '0;
      count_r     <= '0;
      fhead_r     <= '0;
      fsize_r     <= '0;
      lsize_r     <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      init_r      <= init_nxt;
      count_r     <= count_nxt;
      fhead_r     <= fhead_nxt;
      fsize_r     <= fsize_nxt;
      lsize_r     <= lsize_nxt;
      nres_r      <= nres_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fifo_r <= fifo_nxt;
    thr_r  <= thr_nxt;
    dl_r   <= dl_nxt;
    pos_r  <= pos_nxt;
    d_r    <= d_nxt;
    tid_r  <= tid_nxt;
    if (emit) begin
      kind_r   <= e_kind;
      thread_r <= e_thr;
      cnow_r   <= count_nxt[16:0];
      last_r   <= e_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_released_thread = thread_r;
  assign out_count_now       = cnow_r;
  assign out_last            = last_r;

endmodule

FILE: sv/timed_counting_semaphore_top.sv
// Top level of the timed counting semaphore: controller, datapath and checks.
// One counting semaphore with a 16-deep FIFO for waits without limit and a
// 16-deep expiry list, kept as deltas, for waits with a timeout. Each input
// transaction (wait, signal or tick) yields its result transactions on the
// out_ channel; out_last marks the final one. A wait that is granted, queued
// in the FIFO or rejected, and every signal, completes without leaving idle.
// A wait with a timeout walks the list one entry per cycle and then inserts.
// A tick first decrements the head delta, then releases due threads one per
// cycle while the output is not stalled, up to 16 per tick, and then falls
// back to idle; heads still due go out on the next tick. A result sits in an
// output register; a new transaction is taken only once that register is
// empty or its result leaves in the same cycle, and only while the block is
// idle. Write initial_count via cfg_ only while idle; it reloads the count if
// no thread is blocked.
module timed_counting_semaphore_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_thread_id,
  input  logic [15:0]        in_timeout,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_released_thread,
  output logic signed [16:0] out_count_now,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  tcs_pkg::dp_status_t st;
  tcs_pkg::op_t        op;
  logic                cfg_we;

  // Take a config write only while the controller sits idle.
  assign cfg_we = cfg_valid && cfg_ready;

  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .st        (st),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .op        (op)
  );

  tcs_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_thread_id        (in_thread_id),
    .in_timeout          (in_timeout),
    .out_stall           (out_stall),
    .st                  (st),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_released_thread (out_released_thread),
    .out_count_now       (out_count_now),
    .out_last            (out_last)
  );

  // A transaction is only taken when the result register can take its result.
  a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("input taken while result register blocked");

  // A negative count is minus the number of blocked threads.
  a_count_matches_waiters: assert property (@(posedge clk) disable iff (!rst_n)
    st.count[tcs_pkg::COUNT_W-1] |->
      ((st.count + tcs_pkg::COUNT_W'(st.fifo_size) +
        tcs_pkg::COUNT_W'(st.list_size)) == '0))
    else $error("count out of step with blocked threads");

  // Queue occupancy never passes capacity.
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st.fifo_size <= tcs_pkg::SIZE_W'(tcs_pkg::MAX_WAITERS)) &&
    (st.list_size <= tcs_pkg::SIZE_W'(tcs_pkg::MAX_WAITERS)))
    else $error("queue size beyond capacity");

endmodule

FILE: tb/tb_timed_counting_semaphore_top.sv
// Testbench for the timed counting semaphore: random and directed traffic with a scoreboard.
`timescale 1ns / 1ps

module tb_timed_counting_semaphore_top;

  // One expected result transaction.
  typedef struct {
    tcs_pkg::kind_t kind;
    logic [7:0]     thr;
    logic [16:0]    cnt;
    logic           last;
  } sem_result_t;

  // Scoreboard: own copy of the semaphore state, predicts results per input
  // transaction and checks each result transaction against the oldest one.
  class sem_scoreboard;
    int          init_count;
    int          count;
    logic [7:0]  fifo_thr [tcs_pkg::MAX_WAITERS];
    int          fifo_head;
    int          fifo_size;
    logic [7:0]  list_thr [tcs_pkg::MAX_WAITERS];
    int          list_dly [tcs_pkg::MAX_WAITERS];
    int          list_size;
    sem_result_t pending_q[$];
    int          errors;

    function new();
      init_count = 0;
      count      = 0;
      fifo_head  = 0;
      fifo_size  = 0;
      list_size  = 0;
      errors     = 0;
    endfunction

    function void push(tcs_pkg::kind_t k, logic [7:0] t);
      sem_result_t r;
      r.kind = k;
      r.thr  = t;
      r.cnt  = count[16:0];
      r.last = 1'b0;
      pending_q.push_back(r);
    endfunction

    function void list_insert(logic [7:0] t, int d);
      int pos;
      pos = 0;
      while (pos < list_size && d > list_dly[pos]) begin
        d -= list_dly[pos];
        pos++;
      end
      if (pos < list_size) list_dly[pos] -= d;
      for (int k = list_size; k > pos; k--) begin
        list_thr[k] = list_thr[k-1];
        list_dly[k] = list_dly[k-1];
      end
      list_thr[pos] = t;
      list_dly[pos] = d;
      list_size++;
    endfunction

    function logic [7:0] list_pop();
      logic [7:0] t;
      int h;
      t = list_thr[0];
      h = list_dly[0];
      for (int k = 1; k < list_size; k++) begin
        list_thr[k-1] = list_thr[k];
        list_dly[k-1] = list_dly[k];
      end
      list_size--;
      if (list_size > 0) list_dly[0] += h;
      return t;
    endfunction

    function void write_config(logic [15:0] v);
      init_count = v;
      if (fifo_size == 0 && list_size == 0) count = init_count;
    endfunction

    // Note one accepted input transaction and queue its expected results.
    function void note_input(tcs_pkg::cmd_t c, logic [7:0] tid, logic [15:0] tmo);
      int n;
      n = 0;
      case (c)
        tcs_pkg::CMD_WAIT: begin
          if (count - 1 >= 0) begin
            count--;
            push(tcs_pkg::KIND_GRANTED, tid); n++;
          end else if (tmo == 0) begin
            if (fifo_size >= tcs_pkg::MAX_WAITERS) begin
              push(tcs_pkg::KIND_FULL, tid); n++;
            end else begin
              fifo_thr[(fifo_head + fifo_size) % tcs_pkg::MAX_WAITERS] = tid;
              fifo_size++;
              count--;
              push(tcs_pkg::KIND_BLOCKED, tid); n++;
            end
          end else if (list_size >= tcs_pkg::MAX_WAITERS) begin
            push(tcs_pkg::KIND_FULL, tid); n++;
          end else begin
            list_insert(tid, tmo);
            count--;
            push(tcs_pkg::KIND_BLOCKED, tid); n++;
          end
        end
        tcs_pkg::CMD_SIGNAL: begin
          if (count < tcs_pkg::COUNT_TOP) count++;
          if (count <= 0 && fifo_size > 0) begin
            logic [7:0] t;
            t = fifo_thr[fifo_head];
            fifo_head = (fifo_head + 1) % tcs_pkg::MAX_WAITERS;
            fifo_size--;
            push(tcs_pkg::KIND_SIG_REL, t); n++;
          end else if (count <= 0 && list_size > 0) begin
            push(tcs_pkg::KIND_SIG_REL, list_pop()); n++;
          end else begin
            push(tcs_pkg::KIND_SIG_NONE, 8'd0); n++;
          end
        end
        tcs_pkg::CMD_TICK: begin
          if (list_size > 0 && list_dly[0] > 0) list_dly[0]--;
          while (list_size > 0 && list_dly[0] == 0 && n < tcs_pkg::MAX_RESULTS) begin
            logic [7:0] t;
            t = list_pop();
            count++;
            push(tcs_pkg::KIND_TMO_REL, t); n++;
          end
        end
        default: ;
      endcase
      if (n > 0) pending_q[$].last = 1'b1;
    endfunction

    // Check one accepted result transaction against the oldest expectation.
    function void check_result(logic [2:0] k, logic [7:0] t, logic [16:0] c, logic l);
      sem_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result kind=%0d thread=%0d count=%0d last=%0b",
                   k, t, $signed(c), l);
        return;
      end
      e = pending_q.pop_front();
      if (k !== e.kind || t !== e.thr || c !== e.cnt || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp kind=%0d thread=%0d count=%0d last=%0b, got %0d %0d %0d %0b",
                   e.kind, e.thr, $signed(e.cnt), e.last, k, t, $signed(c), l);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_thread_id;
  logic [15:0] in_timeout;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_released_thread;
  logic signed [16:0] out_count_now;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  sem_scoreboard sb;
  int idle_pct;
  int stall_pct;

  timed_counting_semaphore_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_thread_id       (in_thread_id),
    .in_timeout         (in_timeout),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_released_thread(out_released_thread),
    .out_count_now      (out_count_now),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: check accepted transactions, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_released_thread, out_count_now, out_last);
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Drive one input transaction; hold it until the block takes it.
  task automatic send_item(tcs_pkg::cmd_t c, logic [7:0] tid, logic [15:0] tmo);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_thread_id <= tid;
    in_timeout   <= tmo;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, tid, tmo);
  endtask

  // Drop valid and hold off until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Write initial_count while idle; give a silent tick time to finish first.
  task automatic write_initial(logic [15:0] v);
    drain();
    repeat (25) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_config(v);
  endtask

  // Random transaction, weighted so that both queues fill up and drain.
  task automatic send_random();
    int r;
    int t;
    logic [15:0] tmo;
    r = $urandom_range(99);
    if (r < 45) begin
      t = $urandom_range(99);
      if (t < 40)      tmo = 16'd0;
      else if (t < 85) tmo = 16'($urandom_range(6, 1));
      else if (t < 95) tmo = 16'($urandom_range(65535, 1));
      else             tmo = 16'hFFFF;
      send_item(tcs_pkg::CMD_WAIT, 8'($urandom_range(255)), tmo);
    end else if (r < 65) begin
      send_item(tcs_pkg::CMD_SIGNAL, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end else if (r < 97) begin
      send_item(tcs_pkg::CMD_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end else begin
      send_item(tcs_pkg::CMD_NONE, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    logic [15:0] cfg_vals [5];
    sb           = new();
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = tcs_pkg::CMD_NONE;
    in_thread_id = 8'd0;
    in_timeout   = 16'd0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 16'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored command, silent tick, signal with nobody blocked,
    // granted wait, then fill the FIFO to overflow.
    send_item(tcs_pkg::CMD_NONE, 8'hFF, 16'hFFFF);
    send_item(tcs_pkg::CMD_TICK, 8'd0, 16'd0);
    send_item(tcs_pkg::CMD_SIGNAL, 8'd0, 16'd0);
    send_item(tcs_pkg::CMD_WAIT, 8'hFF, 16'd0);
    for (int i = 0; i < tcs_pkg::MAX_WAITERS + 1; i++)
      send_item(tcs_pkg::CMD_WAIT, 8'(i * 15), 16'd0);
    // Timed waiters with equal expiry, released together on one tick.
    send_item(tcs_pkg::CMD_WAIT, 8'hAA, 16'd1);
    send_item(tcs_pkg::CMD_WAIT, 8'h55, 16'd1);
    send_item(tcs_pkg::CMD_TICK, 8'd0, 16'd0);
    send_item(tcs_pkg::CMD_SIGNAL, 8'd0, 16'd0);

    cfg_vals = '{16'd2, 16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(3))};
    for (int ph = 0; ph < 5; ph++) begin
      write_initial(cfg_vals[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      // The saturated count gets a few signals right away.
      if (cfg_vals[ph] == 16'hFFFF) begin
        send_item(tcs_pkg::CMD_SIGNAL, 8'd1, 16'd0);
        send_item(tcs_pkg::CMD_SIGNAL, 8'd2, 16'd0);
      end
      for (int i = 0; i < 48; i++) begin
        send_random();
        if (i == 24) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
